>>> design/lr_pkg.sv
// Package for the line rasterizer: sizes, register indexes and the queued line record.
// No dependencies; every other file of the block depends on it.
package lr_pkg;

  localparam int MAX_SCREEN_SIZE = 64;

  // Field widths fixed by the external interface.
  localparam int IN_COORD_W = 7;
  localparam int OUT_COORD_W = 6;
  localparam int COLOR_W = 32;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 1;

  // Internal coordinate, delta and error widths.
  localparam int PIX_W = $clog2(MAX_SCREEN_SIZE);
  localparam int ACC_W = PIX_W + 1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] SCREEN_SIZE_MAX = CFG_W'(MAX_SCREEN_SIZE);

  // One classified line, ready to walk.
  typedef struct packed {
    logic [PIX_W-1:0] x0;
    logic [PIX_W-1:0] y0;
    logic step_x_pos;
    logic step_y_pos;
    logic x_major;
    logic [PIX_W-1:0] den;
    logic [PIX_W-1:0] add;
    logic [COLOR_W-1:0] color;
  } line_cmd_t;

  // Write side of the line queue.
  typedef struct packed {
    logic push;
    line_cmd_t cmd;
  } queue_wr_t;

  // Read side of the line queue.
  typedef struct packed {
    logic valid;
    line_cmd_t cmd;
  } queue_rd_t;

endpackage

>>> design/lr_cmd_if.sv
// Line command channel: valid/ready handshake with two endpoints and a color.
// Depends on lr_pkg for field widths.
interface lr_cmd_if;
  logic valid;
  logic ready;
  logic [lr_pkg::IN_COORD_W-1:0] start_x;
  logic [lr_pkg::IN_COORD_W-1:0] start_y;
  logic [lr_pkg::IN_COORD_W-1:0] end_x;
  logic [lr_pkg::IN_COORD_W-1:0] end_y;
  logic [lr_pkg::COLOR_W-1:0] draw_color;

  modport source (output valid, start_x, start_y, end_x, end_y, draw_color, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, draw_color, output ready);
endinterface

>>> design/lr_pix_if.sv
// Pixel channel: valid/ready handshake carrying one pixel word.
// Depends on lr_pkg for field widths.
interface lr_pix_if;
  logic valid;
  logic ready;
  logic [lr_pkg::OUT_COORD_W-1:0] pixel_x;
  logic [lr_pkg::OUT_COORD_W-1:0] pixel_y;
  logic [lr_pkg::COLOR_W-1:0] pixel_color;
  logic last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

>>> design/line_rasterizer.sv
// Line rasterizer: takes line commands (two endpoints and a 32-bit color) and
// emits one pixel word per point of the Bresenham walk from the first endpoint
// to the second, both included, with last_pixel set on the final one. A command
// with any coordinate at or beyond the screen width or height (registers above
// 64 act as 64, zero rejects everything) is taken and dropped. The front end
// classifies an accepted command in the cycle it is accepted and writes it to a
// two-entry line queue on that edge. The walker loads it from the queue on the
// next edge when free and then produces one pixel per cycle while the pixel
// channel is ready. A line of major-axis delta d gives d + 1 pixel words (1 to
// 64). The walker takes the next queued line on the same edge its final pixel
// is taken, so lines already queued stream with no gap, and the front end keeps
// accepting while the queue has room. Screen size writes through the cfg port
// take effect for commands accepted after the write; write them only while no
// command is in flight.
// Depends on lr_pkg, lr_cmd_if, lr_pix_if, lr_queue, lr_front and lr_walker.
module line_rasterizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lr_pkg::CFG_W-1:0]      cfg_wdata,
  lr_cmd_if.sink                        in_cmd,
  lr_pix_if.source                      out_pix
);
  import lr_pkg::*;

  queue_wr_t q_wr;
  queue_rd_t q_rd;
  logic q_full;
  logic q_pop;

  // Check, classify and push accepted lines.
  lr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (in_cmd),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  // Hold lines waiting for the walker.
  lr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .rd    (q_rd),
    .pop   (q_pop)
  );

  // Walk the head line and drive the pixel words.
  lr_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .q_rd  (q_rd),
    .q_pop (q_pop),
    .pix   (out_pix)
  );
endmodule

>>> design/lr_queue.sv
// Short register queue of classified lines between the front and the walker.
// Depends on lr_pkg.
module lr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  lr_pkg::queue_wr_t  wr,
  output logic               full,
  output lr_pkg::queue_rd_t  rd,
  input  logic               pop
);
  import lr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  line_cmd_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic do_push;
  logic do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign rd.valid = (count_r != '0);
  assign rd.cmd = mem_r[rd_ptr_r];
  assign do_push = wr.push && !full;
  assign do_pop = pop && rd.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr.cmd;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("line queue holds more entries than its depth");
  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("line queue lost a pushed entry");
endmodule

>>> design/lr_front.sv
// Front end: holds the screen size registers, takes line commands, drops
// off-screen ones and classifies the rest into walk parameters. Depends on lr_pkg.
module lr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lr_pkg::CFG_W-1:0]      cfg_wdata,
  lr_cmd_if.sink                        cmd,
  input  logic                          q_full,
  output lr_pkg::queue_wr_t             q_wr
);
  import lr_pkg::*;

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [CFG_W-1:0] width_eff;
  logic [CFG_W-1:0] height_eff;
  logic on_screen;
  logic [PIX_W-1:0] x1, y1, x2, y2, dx, dy;
  logic sx_pos, sy_pos, x_major;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= SCREEN_SIZE_MAX;
      height_r <= SCREEN_SIZE_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH: width_r <= cfg_wdata;
        REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff = (width_r > SCREEN_SIZE_MAX) ? SCREEN_SIZE_MAX : width_r;
    height_eff = (height_r > SCREEN_SIZE_MAX) ? SCREEN_SIZE_MAX : height_r;
    on_screen = (cmd.start_x < width_eff) && (cmd.end_x < width_eff) &&
                (cmd.start_y < height_eff) && (cmd.end_y < height_eff);

    x1 = PIX_W'(cmd.start_x);
    y1 = PIX_W'(cmd.start_y);
    x2 = PIX_W'(cmd.end_x);
    y2 = PIX_W'(cmd.end_y);
    sx_pos = (x2 >= x1);
    sy_pos = (y2 >= y1);
    dx = sx_pos ? (x2 - x1) : (x1 - x2);
    dy = sy_pos ? (y2 - y1) : (y1 - y2);
    x_major = (dx >= dy);

    q_wr.push = cmd.valid && !q_full && on_screen;
    q_wr.cmd.x0 = x1;
    q_wr.cmd.y0 = y1;
    q_wr.cmd.step_x_pos = sx_pos;
    q_wr.cmd.step_y_pos = sy_pos;
    q_wr.cmd.x_major = x_major;
    q_wr.cmd.den = x_major ? dx : dy;
    q_wr.cmd.add = x_major ? dy : dx;
    q_wr.cmd.color = cmd.draw_color;
  end

  // Off-screen commands are taken and dropped in the same cycle.
  assign cmd.ready = !q_full;
endmodule

>>> design/lr_walker.sv
// Back end: walks one queued line a pixel per cycle, while the pixel channel is
// ready, with the Bresenham error term and drives the pixel channel from registers. Depends on lr_pkg.
module lr_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  lr_pkg::queue_rd_t  q_rd,
  output logic               q_pop,
  lr_pix_if.source           pix
);
  import lr_pkg::*;

  typedef enum logic {IDLE, WALK} walk_state_t;

  walk_state_t state_r;
  line_cmd_t cmd_r;
  logic [PIX_W-1:0] x_r;
  logic [PIX_W-1:0] y_r;
  logic [ACC_W-1:0] acc_r;
  logic [PIX_W-1:0] rem_r;

  logic fire;
  logic at_last;
  logic load;
  logic [ACC_W-1:0] acc_sum;
  logic step_minor;
  logic [ACC_W-1:0] acc_nxt;
  logic [PIX_W-1:0] x_nxt;
  logic [PIX_W-1:0] y_nxt;
  logic move_x;
  logic move_y;

  always_comb begin
    fire = pix.valid && pix.ready;
    at_last = (rem_r == '0);
    load = q_rd.valid && ((state_r == IDLE) || (fire && at_last));
    acc_sum = acc_r + ACC_W'(cmd_r.add);
    step_minor = (acc_sum >= ACC_W'(cmd_r.den));
    acc_nxt = step_minor ? (acc_sum - ACC_W'(cmd_r.den)) : acc_sum;
    move_x = cmd_r.x_major || step_minor;
    move_y = !cmd_r.x_major || step_minor;
    x_nxt = !move_x ? x_r : (cmd_r.step_x_pos ? x_r + PIX_W'(1) : x_r - PIX_W'(1));
    y_nxt = !move_y ? y_r : (cmd_r.step_y_pos ? y_r + PIX_W'(1) : y_r - PIX_W'(1));
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      case (state_r)
        IDLE: begin
          if (load) begin
            state_r <= WALK;
          end
        end
        WALK: begin
          if (fire && at_last && !load) begin
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
      if (load) begin
        cmd_r <= q_rd.cmd;
        x_r <= q_rd.cmd.x0;
        y_r <= q_rd.cmd.y0;
        acc_r <= ACC_W'(q_rd.cmd.den >> 1);
        rem_r <= q_rd.cmd.den;
      end else if (fire) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        acc_r <= acc_nxt;
        rem_r <= rem_r - PIX_W'(1);
      end
    end
  end

  assign pix.valid = (state_r == WALK);
  assign pix.pixel_x = OUT_COORD_W'(x_r);
  assign pix.pixel_y = OUT_COORD_W'(y_r);
  assign pix.pixel_color = cmd_r.color;
  assign pix.last_pixel = at_last;

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> ((state_r == IDLE) || (fire && at_last)))
    else $error("walker took a line while another was still in flight");
  a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !at_last) |=> (state_r == WALK) && (rem_r == $past(rem_r) - PIX_W'(1)))
    else $error("walker stopped before the last pixel");
  a_err_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == WALK) && (cmd_r.den != '0)) |-> (acc_r < ACC_W'(cmd_r.den)))
    else $error("error term left its range");
endmodule

>>> sim/testbench.sv
// Testbench for line_rasterizer: drives line commands, predicts the Bresenham
// pixel stream in place and checks every pixel word. Depends on lr_pkg,
// lr_cmd_if, lr_pix_if and the line_rasterizer RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int IDLE_PCT = 29;      // chance in percent that a side idles in a cycle
  localparam int DRAIN_CYCLES = 8;   // let a dropped command clear the front end
  localparam int TAIL_CYCLES = 20;   // quiet time after the last pixel
  localparam int STALL_LIMIT = 2000; // cycles with no handshake before giving up
  localparam int MAX_REPORTS = 10;

  // One line command as the sender sees it.
  typedef struct packed {
    logic [lr_pkg::IN_COORD_W-1:0] start_x;
    logic [lr_pkg::IN_COORD_W-1:0] start_y;
    logic [lr_pkg::IN_COORD_W-1:0] end_x;
    logic [lr_pkg::IN_COORD_W-1:0] end_y;
    logic [lr_pkg::COLOR_W-1:0]    color;
  } line_req_t;

  // One pixel word as it should appear on the output channel.
  typedef struct packed {
    logic [lr_pkg::OUT_COORD_W-1:0] x;
    logic [lr_pkg::OUT_COORD_W-1:0] y;
    logic [lr_pkg::COLOR_W-1:0]     color;
    logic                           last;
  } pix_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lr_pkg::CFG_W-1:0] cfg_wdata;

  lr_cmd_if cmd_bus ();
  lr_pix_if pix_bus ();

  line_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (cmd_bus),
    .out_pix   (pix_bus)
  );

  // Shadow copy of the screen size registers, as last written.
  logic [lr_pkg::CFG_W-1:0] width_reg = 7'd64;
  logic [lr_pkg::CFG_W-1:0] height_reg = 7'd64;

  pix_word_t pending_pixels[$];   // pixels owed by accepted lines, oldest first
  int errors = 0;
  bit steady = 0;                 // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Effective size: anything above the maximum screen acts as the maximum.
  function automatic int clip_size(logic [lr_pkg::CFG_W-1:0] v);
    return (v > lr_pkg::MAX_SCREEN_SIZE) ? lr_pkg::MAX_SCREEN_SIZE : int'(v);
  endfunction

  // Walk one line the Bresenham way and queue every pixel it must produce.
  // Off-screen endpoints (or a zero-sized screen) produce nothing.
  function automatic void rasterize_line(line_req_t ln);
    int w, h, x, y, x_end, y_end, dx, dy, step_x, step_y, den, acc, add, steps, i;
    bit x_major;
    pix_word_t p;
    w = clip_size(width_reg);
    h = clip_size(height_reg);
    x = int'(ln.start_x);
    y = int'(ln.start_y);
    x_end = int'(ln.end_x);
    y_end = int'(ln.end_y);
    if (x >= w || x_end >= w || y >= h || y_end >= h) return;
    dx = (x_end >= x) ? x_end - x : x - x_end;
    dy = (y_end >= y) ? y_end - y : y - y_end;
    step_x = (x_end >= x) ? 1 : -1;
    step_y = (y_end >= y) ? 1 : -1;
    // x is the major axis on a tie
    x_major = (dx >= dy);
    den = x_major ? dx : dy;
    add = x_major ? dy : dx;
    acc = den / 2;
    steps = den;
    for (i = 0; i <= steps; i++) begin
      p.x = 6'(x);
      p.y = 6'(y);
      p.color = ln.color;
      p.last = (i == steps);
      pending_pixels.push_back(p);
      acc += add;
      if (acc >= den) begin
        acc -= den;
        if (x_major) y += step_y;
        else x += step_x;
      end
      if (x_major) x += step_x;
      else y += step_y;
    end
  endfunction

  // Send one command: idle a random number of cycles, present the word and
  // hold it until the block takes it. Valid stays high on return so that a
  // following command can go out back to back.
  task automatic send_line(line_req_t ln);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.start_x <= ln.start_x;
    cmd_bus.start_y <= ln.start_y;
    cmd_bus.end_x <= ln.end_x;
    cmd_bus.end_y <= ln.end_y;
    cmd_bus.draw_color <= ln.color;
    do @(posedge clk); while (!cmd_bus.ready);
    rasterize_line(ln);
  endtask

  task automatic send_coords(int sx, int sy, int ex, int ey, logic [31:0] color);
    line_req_t ln;
    ln.start_x = 7'(sx);
    ln.start_y = 7'(sy);
    ln.end_x = 7'(ex);
    ln.end_y = 7'(ey);
    ln.color = color;
    send_line(ln);
  endtask

  // Write both size registers once the block has gone quiet: drop valid,
  // drain every owed pixel, then give a rejected command time to clear.
  task automatic set_screen(logic [lr_pkg::CFG_W-1:0] w, logic [lr_pkg::CFG_W-1:0] h);
    cmd_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= lr_pkg::REG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    width_reg = w;
    cfg_index <= lr_pkg::REG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    height_reg = h;
    cfg_we <= 1'b0;
  endtask

  // Random command: mostly on-screen endpoints, a good share of them short
  // lines, and some noise over the whole 7-bit range.
  function automatic line_req_t random_line();
    line_req_t ln;
    int w, h, ex, ey;
    w = clip_size(width_reg);
    h = clip_size(height_reg);
    ln.color = $urandom;
    if (w == 0 || h == 0 || $urandom_range(0, 99) < 15) begin
      ln.start_x = 7'($urandom_range(0, 127));
      ln.start_y = 7'($urandom_range(0, 127));
      ln.end_x = 7'($urandom_range(0, 127));
      ln.end_y = 7'($urandom_range(0, 127));
      return ln;
    end
    ln.start_x = 7'($urandom_range(0, w - 1));
    ln.start_y = 7'($urandom_range(0, h - 1));
    if ($urandom_range(0, 99) < 40) begin
      ex = int'(ln.start_x) + $urandom_range(0, 16) - 8;
      ey = int'(ln.start_y) + $urandom_range(0, 16) - 8;
      ln.end_x = 7'((ex < 0) ? 0 : (ex >= w) ? w - 1 : ex);
      ln.end_y = 7'((ey < 0) ? 0 : (ey >= h) ? h - 1 : ey);
    end else begin
      ln.end_x = 7'($urandom_range(0, w - 1));
      ln.end_y = 7'($urandom_range(0, h - 1));
    end
    return ln;
  endfunction

  function automatic logic [lr_pkg::CFG_W-1:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return lr_pkg::CFG_W'($urandom_range(8, 64));
    if (pick < 85) return lr_pkg::CFG_W'($urandom_range(65, 127));
    return lr_pkg::CFG_W'($urandom_range(0, 7));
  endfunction

  // Receiver: check each taken pixel against the oldest owed one, then pick
  // the next cycle's ready. Check first so the sampled ready is the old one.
  always @(posedge clk) begin
    pix_word_t want;
    if (rst_n && pix_bus.valid && pix_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%0b", $realtime,
                   pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.pixel_color, pix_bus.last_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (pix_bus.pixel_x !== want.x || pix_bus.pixel_y !== want.y ||
            pix_bus.pixel_color !== want.color || pix_bus.last_pixel !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $write("%0t: pixel mismatch: expected x=%0d y=%0d color=%h last=%0b,",
                   $realtime, want.x, want.y, want.color, want.last);
            $display(" got x=%0d y=%0d color=%h last=%0b", pix_bus.pixel_x,
                     pix_bus.pixel_y, pix_bus.pixel_color, pix_bus.last_pixel);
          end
        end
      end
    end
    pix_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Default 64x64 screen: single points, full-width and full-height lines both
  // ways, both diagonals, shallow and steep slopes, and off-screen rejects.
  task automatic test_default_screen();
    send_coords(0, 0, 0, 0, 32'h0000_0000);
    send_coords(5, 5, 5, 5, 32'hFFFF_FFFF);
    send_coords(0, 10, 63, 10, 32'h1234_5678);
    send_coords(63, 20, 0, 20, 32'h8765_4321);
    send_coords(7, 0, 7, 63, 32'hA5A5_A5A5);
    send_coords(7, 63, 7, 0, 32'h5A5A_5A5A);
    send_coords(0, 0, 63, 63, 32'hFFFF_0000);
    send_coords(63, 0, 0, 63, 32'h0000_FFFF);
    send_coords(0, 0, 63, 31, 32'hDEAD_BEEF);
    send_coords(10, 0, 20, 63, 32'hCAFE_F00D);
    send_coords(2, 3, 5, 40, 32'h0F0F_0F0F);
    send_coords(64, 0, 0, 0, 32'hFFFF_FFFF);
    send_coords(0, 0, 10, 127, 32'h1111_1111);
    send_coords(100, 5, 5, 5, 32'h2222_2222);
  endtask

  // Oversized registers act as 64: coordinate 63 passes, 64 is dropped.
  task automatic test_oversized_screen();
    set_screen(7'd127, 7'd65);
    send_coords(63, 63, 0, 0, 32'h3333_3333);
    send_coords(0, 0, 64, 0, 32'h4444_4444);
    send_coords(0, 0, 0, 64, 32'h5555_5555);
    send_coords(1, 62, 40, 1, 32'h6666_6666);
  endtask

  // Zero-sized screen drops everything, on either axis.
  task automatic test_zero_screen();
    set_screen(7'd0, 7'd64);
    send_coords(0, 0, 0, 0, 32'h7777_7777);
    send_coords(3, 4, 5, 6, 32'h8888_8888);
    set_screen(7'd64, 7'd0);
    send_coords(0, 0, 0, 0, 32'h9999_9999);
  endtask

  // One-pixel screen: only the origin survives.
  task automatic test_tiny_screen();
    set_screen(7'd1, 7'd1);
    send_coords(0, 0, 0, 0, 32'hABCD_EF01);
    send_coords(1, 0, 0, 0, 32'hABCD_EF02);
    send_coords(0, 0, 0, 1, 32'hABCD_EF03);
  endtask

  // Random phases, each under its own screen size.
  task automatic test_random_lines();
    int phase, n;
    for (phase = 0; phase < 4; phase++) begin
      if (phase == 0) set_screen(7'd64, 7'd64);
      else set_screen(random_size(), random_size());
      for (n = 0; n < 50; n++) send_line(random_line());
    end
  endtask

  // Long stretch with neither side idling, so lines stream back to back.
  task automatic test_steady_stream();
    int n;
    set_screen(7'd64, 7'd64);
    steady = 1;
    for (n = 0; n < 60; n++) send_line(random_line());
    cmd_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    steady = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = lr_pkg::REG_SCREEN_WIDTH;
    cfg_wdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.start_x = '0;
    cmd_bus.start_y = '0;
    cmd_bus.end_x = '0;
    cmd_bus.end_y = '0;
    cmd_bus.draw_color = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_screen();
    test_oversized_screen();
    test_zero_screen();
    test_tiny_screen();
    test_random_lines();
    test_steady_stream();

    // Drain, then hold a while longer so any stray pixel shows up.
    cmd_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
